/* rtl/assert_macros.svh */
// assertion macros shared by the deque modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define CDQ_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants shared by the circular deque modules.
// ----------------------------------------------------------------------------
package cdq_pkg;

   // payload types
   typedef logic        [2:0]  func_type;
   typedef logic signed [31:0] word_type;

   // operation codes
   localparam func_type F_PUSH_FRONT = 3'd0;
   localparam func_type F_PUSH_REAR  = 3'd1;
   localparam func_type F_POP_FRONT  = 3'd2;
   localparam func_type F_POP_REAR   = 3'd3;
   localparam func_type F_PEEK_FRONT = 3'd4;
   localparam func_type F_PEEK_REAR  = 3'd5;

   // answer of a pop or peek that finds nothing
   localparam word_type EMPTY_WORD = -32'sd1;

   // configuration register
   localparam int         CAP_W      = 5;
   localparam logic [4:0] CAP_RESET  = 5'd16;
   localparam int         CSR_ADDR_W = 3;
   localparam int         CSR_DATA_W = 32;
   localparam logic       CSR_IDX_CAPACITY = 1'b0;

   // commands from the controller to the datapath
   typedef struct packed {
      logic exec;      // item accepted this cycle
      logic cap_load;  // capacity register written this cycle
   } cdq_cmd_type;

endpackage

/* rtl/cdq_ifs.sv */
// ----------------------------------------------------------------------------
// cdq request and response channels
// Valid/ready channels carrying deque operations and their results.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   import cdq_pkg::*;

   logic     valid;
   logic     ready;
   func_type func;
   word_type push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;

   logic     valid;
   logic     ready;
   word_type read_value;
   logic     ok;
   logic     is_empty;
   logic     is_full;

   modport source (output valid, output read_value, output ok, output is_empty,
                   output is_full, input ready);
   modport sink   (input valid, input read_value, input ok, input is_empty,
                   input is_full, output ready);
endinterface

/* rtl/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl
// Controller: item handshake state machine and register write decode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   output cdq_pkg::cdq_cmd_type                cmd
);
   import cdq_pkg::*;

   // state codes
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic state_ff;
   logic state_in;

   // next state: take one item, hold its result until taken
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // handshake and commands
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign cmd.exec     = req_valid && req_ready;
   assign cmd.cap_load = csr_psel && csr_penable && csr_pwrite
                         && (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY);

   `CDQ_ASSERT(a_exec_gives_result, clock, reset, cmd.exec |=> rsp_valid, "accepted item gave no result")
   `CDQ_NEVER(a_one_item, clock, reset, req_ready && rsp_valid, "new item taken while result pending")

endmodule

/* rtl/cdq_dpath.sv */
// ----------------------------------------------------------------------------
// cdq_dpath
// Datapath: ring memory, head/tail pointers, occupancy, capacity register
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_dpath #(
   parameter int MAX_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cdq_pkg::cdq_cmd_type                cmd,
   input  cdq_pkg::func_type                   func,
   input  cdq_pkg::word_type                   push_value,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cdq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cdq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output cdq_pkg::word_type                   read_value,
   output logic                                ok,
   output logic                                is_empty,
   output logic                                is_full
);
   import cdq_pkg::*;

   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // ring memory and its registered read
   word_type ring_mem [MAX_DEPTH];
   word_type rd_data_ff;

   // control state
   logic [CAP_W-1:0] cap_raw_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // result register
   logic ok_ff, ok_in;
   logic rd_sel_ff, rd_sel_in;
   logic empty_ff, full_ff;

   // memory access
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_addr;

   // effective capacity
   logic [CMP_W-1:0] cap_ext, cap_cmp;
   logic [CNT_W-1:0] cap_eff;
   logic [IDX_W-1:0] cap_last;

   logic is_push, is_pop, is_peek, is_front;

   // clamp capacity to 1..MAX_DEPTH
   always_comb begin
      cap_ext = CMP_W'(cap_raw_ff);
      if (cap_ext == '0) begin
         cap_cmp = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_DEPTH)) begin
         cap_cmp = CMP_W'(MAX_DEPTH);
      end else begin
         cap_cmp = cap_ext;
      end
      cap_eff  = CNT_W'(cap_cmp);
      cap_last = IDX_W'(cap_eff - CNT_W'(1));
   end

   // operation decode
   assign is_push  = (func == F_PUSH_FRONT) || (func == F_PUSH_REAR);
   assign is_pop   = (func == F_POP_FRONT) || (func == F_POP_REAR);
   assign is_peek  = (func == F_PEEK_FRONT) || (func == F_PEEK_REAR);
   assign is_front = (func == F_PUSH_FRONT) || (func == F_POP_FRONT)
                     || (func == F_PEEK_FRONT);

   // pointer update and memory access for one item
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      occ_in    = occ_ff;
      ok_in     = 1'b0;
      rd_sel_in = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = head_ff;
      if (is_push) begin
         if (occ_ff < cap_eff) begin
            priority if (occ_ff == '0) begin
               head_in  = '0;
               tail_in  = '0;
               mem_addr = '0;
            end else if (is_front) begin
               head_in  = (head_ff == '0) ? cap_last : head_ff - IDX_W'(1);
               mem_addr = head_in;
            end else begin
               tail_in  = (tail_ff >= cap_last) ? '0 : tail_ff + IDX_W'(1);
               mem_addr = tail_in;
            end
            mem_we = cmd.exec;
            occ_in = occ_ff + CNT_W'(1);
            ok_in  = 1'b1;
         end
      end else if (is_pop || is_peek) begin
         if (occ_ff != '0) begin
            mem_addr  = is_front ? head_ff : tail_ff;
            mem_re    = cmd.exec;
            ok_in     = 1'b1;
            rd_sel_in = 1'b1;
            if (is_pop) begin
               priority if (occ_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (is_front) begin
                  head_in = (head_ff >= cap_last) ? '0 : head_ff + IDX_W'(1);
               end else begin
                  tail_in = (tail_ff == '0) ? cap_last : tail_ff - IDX_W'(1);
               end
               occ_in = occ_ff - CNT_W'(1);
            end
         end
      end
   end

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_raw_ff <= CAP_RESET;
         head_ff    <= '0;
         tail_ff    <= '0;
         occ_ff     <= '0;
      end else if (cmd.cap_load) begin
         cap_raw_ff <= csr_pwdata[CAP_W-1:0];
         head_ff    <= '0;
         tail_ff    <= '0;
         occ_ff     <= '0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   // result flags, captured with the item
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff     <= ok_in;
         rd_sel_ff <= rd_sel_in;
         empty_ff  <= (occ_in == '0);
         full_ff   <= (occ_in >= cap_eff);
      end
   end

   // ring memory, one access per item
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= push_value;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_addr];
      end
   end

   // result payload
   assign read_value = rd_sel_ff ? rd_data_ff : EMPTY_WORD;
   assign ok         = ok_ff;
   assign is_empty   = empty_ff;
   assign is_full    = full_ff;

   // register readback
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY)
                       ? CSR_DATA_W'(cap_raw_ff) : '0;

   `CDQ_ASSERT(a_occ_in_cap, clock, reset, occ_ff <= cap_eff, "occupancy above capacity")
   `CDQ_ASSERT(a_empty_ptrs, clock, reset, (occ_ff == '0) |-> (head_ff == '0 && tail_ff == '0), "empty deque with pointers off zero")
   `CDQ_ASSERT(a_ptr_range, clock, reset, head_ff <= cap_last && tail_ff <= cap_last, "pointer beyond capacity")

endmodule

/* rtl/circular_deque_unit.sv */
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed 32-bit words in a ring memory, with a
// capacity register on an APB-style port.
// ----------------------------------------------------------------------------
// Each item is one operation (push/pop/peek at front or rear) and gives one
// result with the word read, ok and the empty/full flags after the operation.
// In the accept cycle the pointers move and the single ring memory port is
// written or read; the registered read and flags then stand in the output
// register until taken, and the next item is accepted the cycle after the
// result is taken. The unit holds one item at a time, so it takes no new
// item while a result is pending. Reset needs no clearing pass; writing
// capacity empties the deque.
module circular_deque_unit #(
   parameter int MAX_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   cdq_req_if.sink                             req,
   cdq_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cdq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cdq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import cdq_pkg::*;

   cdq_cmd_type cmd;

   // register port never waits
   assign csr_pready = 1'b1;

   // controller
   cdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_ready   (req.ready),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .cmd         (cmd)
   );

   // datapath
   cdq_dpath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .func       (req.func),
      .push_value (req.push_value),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .read_value (rsp.read_value),
      .ok         (rsp.ok),
      .is_empty   (rsp.is_empty),
      .is_full    (rsp.is_full)
   );

endmodule

/* tb/cdq_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdq_result_checker
// Watches the request, response and register buses of the circular deque,
// keeps its own copy of the deque contents and compares every result item
// field by field with the answer predicted for the matching request item.
// ----------------------------------------------------------------------------
module cdq_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   cdq_req_if                               req_mon,
   cdq_rsp_if                               rsp_mon,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cdq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                             csr_pready,
   output int unsigned                      pending,
   output int unsigned                      mismatches,
   output int unsigned                      checked
);
   import cdq_pkg::*;

   localparam int DEQUE_DEPTH = 16;
   localparam int DUE_DEPTH   = 16;
   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'(4 * CSR_IDX_CAPACITY);

   // what one result item should carry
   typedef struct packed {
      word_type read_value;
      logic     ok;
      logic     is_empty;
      logic     is_full;
   } deque_answer_type;

   // shadow copy of the deque
   word_type          ring_copy [DEQUE_DEPTH];
   logic [3:0]        front_idx;
   logic [3:0]        rear_idx;
   logic [4:0]        held_words;
   logic [CAP_W-1:0]  capacity_reg;

   // answers waiting for their result items, oldest at the read pointer
   deque_answer_type  answers_due [DUE_DEPTH];
   logic [4:0]        due_wr;
   logic [4:0]        due_rd;
   int unsigned       bad_fields;
   int unsigned       results_seen;

   function automatic void empty_deque();
      held_words = '0;
      front_idx  = '0;
      rear_idx   = '0;
   endfunction

   // perform one operation on the shadow copy and return its answer
   function automatic deque_answer_type apply_op(input func_type f, input word_type v);
      deque_answer_type a;
      logic [4:0]       lim;
      logic             front;
      // zero behaves as one entry, anything past the store as the full store
      lim = (capacity_reg == '0) ? 5'd1 :
            ((capacity_reg > DEQUE_DEPTH) ? 5'(DEQUE_DEPTH) : 5'(capacity_reg));
      a.read_value = EMPTY_WORD;
      a.ok         = 1'b0;
      case (f)
         F_PUSH_FRONT, F_PUSH_REAR: begin
            if (held_words < lim) begin
               if (held_words == '0) begin
                  // first word always lands in entry zero
                  front_idx    = '0;
                  rear_idx     = '0;
                  ring_copy[0] = v;
               end else if (f == F_PUSH_FRONT) begin
                  front_idx = (front_idx == 4'd0) ? 4'(lim - 5'd1) : front_idx - 4'd1;
                  ring_copy[front_idx] = v;
               end else begin
                  rear_idx = ({1'b0, rear_idx} >= lim - 5'd1) ? 4'd0 : rear_idx + 4'd1;
                  ring_copy[rear_idx] = v;
               end
               held_words = held_words + 5'd1;
               a.ok       = 1'b1;
            end
         end
         F_POP_FRONT, F_POP_REAR, F_PEEK_FRONT, F_PEEK_REAR: begin
            if (held_words != '0) begin
               front        = (f == F_POP_FRONT) || (f == F_PEEK_FRONT);
               a.read_value = front ? ring_copy[front_idx] : ring_copy[rear_idx];
               a.ok         = 1'b1;
               if (f == F_POP_FRONT || f == F_POP_REAR) begin
                  if (held_words == 5'd1) begin
                     empty_deque();
                  end else begin
                     if (front)
                        front_idx = ({1'b0, front_idx} >= lim - 5'd1) ? 4'd0 : front_idx + 4'd1;
                     else
                        rear_idx = (rear_idx == 4'd0) ? 4'(lim - 5'd1) : rear_idx - 4'd1;
                     held_words = held_words - 5'd1;
                  end
               end
            end
         end
         default: ;  // undefined codes change nothing
      endcase
      a.is_empty = (held_words == '0);
      a.is_full  = (held_words >= lim);
      return a;
   endfunction

   // follow register writes, predict on request items, compare on result items
   always @(posedge clock) begin
      deque_answer_type want;
      logic [4:0]       due_count;
      if (reset) begin
         empty_deque();
         capacity_reg = CAP_RESET;
         due_wr       = '0;
         due_rd       = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CAPACITY_ADDR) begin
            capacity_reg = csr_pwdata[CAP_W-1:0];
            empty_deque();
         end
         if (req_mon.valid && req_mon.ready) begin
            due_count = due_wr - due_rd;
            if (due_count == 5'(DUE_DEPTH)) begin
               $error("more than %0d operations outstanding", DUE_DEPTH);
               bad_fields++;
            end else begin
               answers_due[due_wr[3:0]] = apply_op(req_mon.func, req_mon.push_value);
               due_wr = due_wr + 5'd1;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_wr == due_rd) begin
               $error("result item with no operation outstanding");
               bad_fields++;
            end else begin
               want   = answers_due[due_rd[3:0]];
               due_rd = due_rd + 5'd1;
               results_seen++;
               if (rsp_mon.read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         want.read_value, rsp_mon.read_value);
                  bad_fields++;
               end
               if (rsp_mon.ok !== want.ok) begin
                  $error("ok: expected %0b, got %0b", want.ok, rsp_mon.ok);
                  bad_fields++;
               end
               if (rsp_mon.is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0b, got %0b", want.is_empty, rsp_mon.is_empty);
                  bad_fields++;
               end
               if (rsp_mon.is_full !== want.is_full) begin
                  $error("is_full: expected %0b, got %0b", want.is_full, rsp_mon.is_full);
                  bad_fields++;
               end
            end
         end
      end
      due_count = due_wr - due_rd;
      pending    <= 32'(due_count);
      mismatches <= bad_fields;
      checked    <= results_seen;
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the circular deque unit: a directed opening on empty, full and
// out-of-range capacity cases, then bursts of random fill and drain traffic
// over several capacities with random idling on both channels and one long
// result stall. The checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
   import cdq_pkg::*;

   localparam int DEQUE_DEPTH    = 16;
   localparam int RANDOM_ITEMS   = 700;
   localparam int PHASES         = 9;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 8;

   // codes outside the defined operations
   localparam func_type F_SPARE_6 = 3'd6;
   localparam func_type F_SPARE_7 = 3'd7;

   localparam logic [CSR_ADDR_W-1:0] CAPACITY_ADDR = CSR_ADDR_W'(4 * CSR_IDX_CAPACITY);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    req_gap_pct;
   int                    rsp_idle_pct;
   logic                  hold_rsp;
   int unsigned           op_tally [8];
   int unsigned           capacity_writes;
   int                    quiet_cycles;

   int unsigned           pending;
   int unsigned           mismatches;
   int unsigned           checked;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   circular_deque_unit #(
      .MAX_DEPTH (DEQUE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cdq_result_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .pending     (pending),
      .mismatches  (mismatches),
      .checked     (checked)
   );

   always #4 clock = ~clock;

   // result side: random back-pressure, plus one long hold once the sender offers items
   initial begin
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !held && req_ch.valid) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // extremes now and then, otherwise any word
   function automatic word_type pick_word();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return EMPTY_WORD;
         3: return '0;
         default: return word_type'($urandom);
      endcase
   endfunction

   // mostly pushes while filling, mostly pops and peeks while draining
   function automatic func_type pick_op(input bit filling);
      int roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return ($urandom_range(1) != 0) ? F_SPARE_7 : F_SPARE_6;
      if (roll < (filling ? 78 : 23))
         return ($urandom_range(1) != 0) ? F_PUSH_REAR : F_PUSH_FRONT;
      return func_type'($urandom_range(F_PEEK_REAR, F_POP_FRONT));
   endfunction

   // offer one item after a random gap; valid stays high for a back-to-back item
   task automatic send_item(input func_type f, input word_type v);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_gap_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= f;
      req_ch.push_value <= v;
      do @(posedge clock); while (!req_ch.ready);
      op_tally[f]++;
   endtask

   task automatic drain_items();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // register write only once the unit has answered everything
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_items();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      capacity_writes++;
   endtask

   // alternating fill and drain bursts sized to the usable depth
   task automatic run_burst_phase(input logic [CAP_W-1:0] cap_val, input int n_items);
      int       depth;
      int       done;
      int       len;
      bit       filling;
      func_type f;
      depth = (cap_val == '0) ? 1 : ((cap_val > DEQUE_DEPTH) ? DEQUE_DEPTH : int'(cap_val));
      write_capacity(cap_val);
      done    = 0;
      filling = 1'b0;
      while (done < n_items) begin
         filling = !filling;
         len     = $urandom_range(2 * depth + 2, 1);
         for (int k = 0; k < len && done < n_items; k++) begin
            f = pick_op(filling);
            send_item(f, pick_word());
            if (f <= F_PEEK_REAR)
               done++;
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      logic [CAP_W-1:0] cap_plan [PHASES];
      cap_plan = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd7, 5'd0, 5'd20, 5'd2, 5'd16};

      req_ch.valid      <= 1'b0;
      req_ch.func       <= F_PEEK_FRONT;
      req_ch.push_value <= '0;
      csr_psel          <= 1'b0;
      csr_penable       <= 1'b0;
      csr_pwrite        <= 1'b0;
      csr_paddr         <= '0;
      csr_pwdata        <= '0;
      hold_rsp          <= 1'b0;
      req_gap_pct       <= 15;
      rsp_idle_pct      <= 88;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty deque: every read-type operation and the undefined codes
      send_item(F_POP_FRONT, pick_word());
      send_item(F_POP_REAR, pick_word());
      send_item(F_PEEK_FRONT, pick_word());
      send_item(F_PEEK_REAR, pick_word());
      send_item(F_SPARE_6, pick_word());
      send_item(F_SPARE_7, pick_word());
      // push into empty, then both ends with extreme words
      send_item(F_PUSH_FRONT, 32'sh7fffffff);
      send_item(F_PUSH_REAR, 32'sh80000000);
      send_item(F_PUSH_FRONT, EMPTY_WORD);
      send_item(F_PUSH_REAR, '0);
      send_item(F_PEEK_FRONT, pick_word());
      send_item(F_PEEK_REAR, pick_word());
      send_item(F_SPARE_7, pick_word());
      // pop all four words, then push one
      send_item(F_POP_REAR, pick_word());
      send_item(F_POP_FRONT, pick_word());
      send_item(F_POP_FRONT, pick_word());
      send_item(F_POP_REAR, pick_word());
      send_item(F_PUSH_REAR, 32'sh5a5aa5a5);

      // single entry: the write empties the deque, the second push is refused
      write_capacity(5'd1);
      send_item(F_POP_FRONT, pick_word());
      send_item(F_PUSH_FRONT, 32'sh12345678);
      send_item(F_PUSH_REAR, 32'sh0badf00d);
      send_item(F_PEEK_REAR, pick_word());
      send_item(F_POP_REAR, pick_word());

      // zero capacity behaves as one entry
      write_capacity(5'd0);
      send_item(F_PUSH_REAR, 32'sh00c0ffee);
      send_item(F_PUSH_FRONT, 32'sh7ead0001);

      // random traffic under three idling patterns
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES / 3) begin
            req_gap_pct  <= 88;
            rsp_idle_pct <= 15;
         end
         if (p == 2 * PHASES / 3) begin
            req_gap_pct  <= 0;
            rsp_idle_pct <= 0;
            hold_rsp     <= 1'b1;
         end
         run_burst_phase(cap_plan[p], RANDOM_ITEMS / PHASES);
      end

      drain_items();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d operations: %0d pushes, %0d pops, %0d peeks, %0d undefined codes",
               op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3] + op_tally[4]
               + op_tally[5] + op_tally[6] + op_tally[7],
               op_tally[F_PUSH_FRONT] + op_tally[F_PUSH_REAR],
               op_tally[F_POP_FRONT] + op_tally[F_POP_REAR],
               op_tally[F_PEEK_FRONT] + op_tally[F_PEEK_REAR],
               op_tally[F_SPARE_6] + op_tally[F_SPARE_7]);
      $display("%0d results compared over %0d capacity writes, with a %0d-cycle result stall",
               checked, capacity_writes, HOLD_CYCLES);
      if (mismatches == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
